@@ hdl/k0es_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// k0es_pkg: shared types and constants of the K0 elastic stress update
// Field widths, register indexes, coefficient record and saturation helpers.
// ---------------------------------------------------------------------------
package k0es_pkg;

   localparam int STRAIN_W = 32;
   localparam int STRESS_W = 56;
   localparam int E_W      = 30;
   localparam int K_W      = 19;
   localparam int AXIS_W   = 2;
   localparam int IDX_W    = 3;
   localparam int COEF_W   = 64;
   localparam int PROD_W   = 96;
   localparam int ACC_W    = 98;
   localparam int LAT_W    = 75;
   localparam int NU_W     = 24;
   localparam int NUM_W    = 88;
   localparam int DEN_W    = 51;
   localparam int REM_W    = 52;
   localparam int CNT_W    = 7;

   localparam logic [AXIS_W-1:0] AXIS_X   = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y   = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z   = 2'd2;
   localparam logic [AXIS_W-1:0] AXIS_BAD = 2'd3;

   localparam logic [IDX_W-1:0] REG_YOUNG = 3'd0;
   localparam logic [IDX_W-1:0] REG_K0_X  = 3'd1;
   localparam logic [IDX_W-1:0] REG_K0_Y  = 3'd2;
   localparam logic [IDX_W-1:0] REG_K0_Z  = 3'd3;
   localparam logic [IDX_W-1:0] REG_AXIS  = 3'd4;

   localparam logic signed [K_W-1:0] K0_RESET = 19'sd8192;

   localparam logic [NU_W-1:0] NU_LOW  = 24'd32440;
   localparam logic [NU_W-1:0] NU_HIGH = 24'd33096;
   localparam logic [NU_W-1:0] NU_MAX  = 24'd16777215;
   localparam logic [COEF_W-1:0] COEF_MAX = 64'h4000_0000_0000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KSUM,
      ST_NU_WAIT,
      ST_BAND,
      ST_MUL,
      ST_C2_GO,
      ST_C2_WAIT,
      ST_C3_GO,
      ST_C3_WAIT,
      ST_C4_GO,
      ST_C4_WAIT
   } coef_state_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] c2;
      logic signed [COEF_W-1:0] c3;
      logic signed [COEF_W-1:0] c4;
      logic signed [K_W-1:0]    ka;
      logic signed [K_W-1:0]    kb;
      logic [AXIS_W-1:0]        axis;
   } coef_type;

   // Round half up, drop 29 fraction bits and clamp to the stress width.
   function automatic logic signed [STRESS_W-1:0] sat_acc(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] t;
      logic [ACC_W-30:0] sh;
      t  = x + (ACC_W'(1) << 28);
      sh = t[ACC_W-1:29];
      if (sh[ACC_W-30:STRESS_W-1] == '0 || sh[ACC_W-30:STRESS_W-1] == '1) begin
         return sh[STRESS_W-1:0];
      end
      return sh[ACC_W-30] ? {1'b1, {(STRESS_W-1){1'b0}}} : {1'b0, {(STRESS_W-1){1'b1}}};
   endfunction

   // Same treatment for the lateral products, which carry 14 fraction bits.
   function automatic logic signed [STRESS_W-1:0] sat_lat(input logic signed [LAT_W-1:0] x);
      logic signed [LAT_W-1:0] t;
      logic [LAT_W-15:0] sh;
      t  = x + (LAT_W'(1) << 13);
      sh = t[LAT_W-1:14];
      if (sh[LAT_W-15:STRESS_W-1] == '0 || sh[LAT_W-15:STRESS_W-1] == '1) begin
         return sh[STRESS_W-1:0];
      end
      return sh[LAT_W-15] ? {1'b1, {(STRESS_W-1){1'b0}}} : {1'b0, {(STRESS_W-1){1'b1}}};
   endfunction

endpackage
`default_nettype wire

@@ hdl/k0es_div.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// k0es_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; quotient rounded half up.
// ---------------------------------------------------------------------------
module k0es_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [k0es_pkg::NUM_W-1:0]    num,
   input  wire logic [k0es_pkg::DEN_W-1:0]    den,
   output logic                               done,
   output logic [k0es_pkg::NUM_W-1:0]         quot
);

   logic [k0es_pkg::NUM_W-1:0] num_ff;
   logic [k0es_pkg::DEN_W-1:0] den_ff;
   logic [k0es_pkg::REM_W-1:0] rem_ff;
   logic [k0es_pkg::CNT_W-1:0] count_ff;
   logic                       active_ff;
   logic                       done_ff;
   logic [k0es_pkg::REM_W:0]   shifted;
   logic                       fits;
   logic                       round_up;

   assign shifted  = {rem_ff, num_ff[k0es_pkg::NUM_W-1]};
   assign fits     = shifted >= (k0es_pkg::REM_W+1)'(den_ff);
   assign round_up = {rem_ff, 1'b0} >= (k0es_pkg::REM_W+1)'(den_ff);
   assign quot     = num_ff + k0es_pkg::NUM_W'(round_up);
   assign done     = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else if (start) begin
         active_ff <= 1'b1;
         done_ff   <= 1'b0;
         count_ff  <= k0es_pkg::CNT_W'(k0es_pkg::NUM_W);
      end else if (active_ff) begin
         count_ff <= count_ff - 1'b1;
         if (count_ff == k0es_pkg::CNT_W'(1)) begin
            active_ff <= 1'b0;
            done_ff   <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (active_ff) begin
         // The dividend register fills with quotient bits from the bottom.
         num_ff <= {num_ff[k0es_pkg::NUM_W-2:0], fits};
         rem_ff <= fits ? k0es_pkg::REM_W'(shifted - (k0es_pkg::REM_W+1)'(den_ff))
                        : shifted[k0es_pkg::REM_W-1:0];
      end
   end

endmodule
`default_nettype wire

@@ hdl/k0es_coef.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// k0es_coef: configuration registers and elastic coefficient sequencer
// Derives the Poisson ratio and the matrix coefficients after every write.
// ---------------------------------------------------------------------------
module k0es_coef (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [k0es_pkg::IDX_W-1:0]    csr_index,
   input  wire logic [k0es_pkg::E_W-1:0]      csr_wr_data,
   output k0es_pkg::coef_type                 coef,
   output logic                               busy
);

   k0es_pkg::coef_state_type state_ff, state_in;

   logic [k0es_pkg::E_W-1:0]           young_ff;
   logic signed [k0es_pkg::K_W-1:0]    kx_ff, ky_ff, kz_ff;
   logic [k0es_pkg::AXIS_W-1:0]        axis_ff;
   logic signed [k0es_pkg::COEF_W-1:0] c2_ff, c3_ff, c4_ff;
   logic [k0es_pkg::NU_W-1:0]          n_ff;
   logic [k0es_pkg::DEN_W-1:0]         den_mag_ff;
   logic [54:0]                        em2_ff, em3_ff;
   logic                               sign2_ff, sign3_ff;

   logic signed [k0es_pkg::K_W-1:0] ka, kb;
   logic signed [19:0]              kq;
   logic signed [20:0]              dk;
   logic [19:0]                     kq_mag;
   logic [20:0]                     dk_mag;
   logic                            nu_div;

   logic [24:0]        one_p;
   logic signed [24:0] one_m;
   logic signed [25:0] one_m2;
   logic signed [51:0] den_full;
   logic [24:0]        one_m_mag;

   logic                          div_start;
   logic [k0es_pkg::NUM_W-1:0]    div_num;
   logic [k0es_pkg::DEN_W-1:0]    div_den;
   logic                          div_done;
   logic [k0es_pkg::NUM_W-1:0]    div_quot;
   logic [k0es_pkg::COEF_W-1:0]   coef_mag;

   always_comb begin
      case (axis_ff)
         k0es_pkg::AXIS_Y: begin
            ka = kz_ff;
            kb = kx_ff;
         end
         k0es_pkg::AXIS_Z: begin
            ka = kx_ff;
            kb = ky_ff;
         end
         default: begin
            ka = ky_ff;
            kb = kz_ff;
         end
      endcase
   end

   // The mean K0 is kept doubled, so the ratio K0/(K0+1) is kq/(kq+2^15).
   assign kq     = 20'(ka) + 20'(kb);
   assign dk     = 21'(kq) + 21'sd32768;
   assign kq_mag = kq[19] ? 20'(-kq) : 20'(kq);
   assign dk_mag = dk[20] ? 21'(-dk) : 21'(dk);
   assign nu_div = (!kq[19] && kq != '0 && !dk[20] && dk != '0) || (kq[19] && dk[20]);

   assign one_p     = 25'd65536 + 25'(n_ff);
   assign one_m     = 25'sd65536 - $signed({1'b0, n_ff});
   assign one_m2    = 26'sd65536 - $signed({1'b0, n_ff, 1'b0});
   assign den_full  = $signed({1'b0, one_p}) * one_m2;
   assign one_m_mag = one_m[24] ? 25'(-one_m) : 25'(one_m);

   assign coef_mag = (div_quot > k0es_pkg::NUM_W'(k0es_pkg::COEF_MAX))
                     ? k0es_pkg::COEF_MAX : div_quot[k0es_pkg::COEF_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= k0es_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (state_ff)
         k0es_pkg::ST_IDLE: ;
         k0es_pkg::ST_KSUM: begin
            div_num = k0es_pkg::NUM_W'({kq_mag, 16'b0});
            div_den = k0es_pkg::DEN_W'(dk_mag);
            if (nu_div) begin
               div_start = 1'b1;
               state_in  = k0es_pkg::ST_NU_WAIT;
            end else begin
               state_in = k0es_pkg::ST_BAND;
            end
         end
         k0es_pkg::ST_NU_WAIT: if (div_done) state_in = k0es_pkg::ST_BAND;
         k0es_pkg::ST_BAND:    state_in = k0es_pkg::ST_MUL;
         k0es_pkg::ST_MUL:     state_in = k0es_pkg::ST_C2_GO;
         k0es_pkg::ST_C2_GO: begin
            div_start = 1'b1;
            div_num   = k0es_pkg::NUM_W'({em2_ff, 32'b0});
            div_den   = den_mag_ff;
            state_in  = k0es_pkg::ST_C2_WAIT;
         end
         k0es_pkg::ST_C2_WAIT: if (div_done) state_in = k0es_pkg::ST_C3_GO;
         k0es_pkg::ST_C3_GO: begin
            div_start = 1'b1;
            div_num   = k0es_pkg::NUM_W'({em3_ff, 32'b0});
            div_den   = den_mag_ff;
            state_in  = k0es_pkg::ST_C3_WAIT;
         end
         k0es_pkg::ST_C3_WAIT: if (div_done) state_in = k0es_pkg::ST_C4_GO;
         k0es_pkg::ST_C4_GO: begin
            div_start = 1'b1;
            div_num   = k0es_pkg::NUM_W'({young_ff, 31'b0});
            div_den   = k0es_pkg::DEN_W'(one_p);
            state_in  = k0es_pkg::ST_C4_WAIT;
         end
         k0es_pkg::ST_C4_WAIT: if (div_done) state_in = k0es_pkg::ST_IDLE;
         default: state_in = k0es_pkg::ST_IDLE;
      endcase
      // Any write starts the derivation over from the new register set.
      if (csr_wr_en) begin
         state_in  = k0es_pkg::ST_KSUM;
         div_start = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         young_ff <= '0;
         kx_ff    <= k0es_pkg::K0_RESET;
         ky_ff    <= k0es_pkg::K0_RESET;
         kz_ff    <= k0es_pkg::K0_RESET;
         axis_ff  <= k0es_pkg::AXIS_Z;
      end else if (csr_wr_en) begin
         case (csr_index)
            k0es_pkg::REG_YOUNG: young_ff <= csr_wr_data;
            k0es_pkg::REG_K0_X:  kx_ff    <= $signed(csr_wr_data[k0es_pkg::K_W-1:0]);
            k0es_pkg::REG_K0_Y:  ky_ff    <= $signed(csr_wr_data[k0es_pkg::K_W-1:0]);
            k0es_pkg::REG_K0_Z:  kz_ff    <= $signed(csr_wr_data[k0es_pkg::K_W-1:0]);
            k0es_pkg::REG_AXIS:  axis_ff  <= csr_wr_data[k0es_pkg::AXIS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         n_ff  <= '0;
      end else begin
         case (state_ff)
            k0es_pkg::ST_KSUM: n_ff <= '0;
            k0es_pkg::ST_NU_WAIT: begin
               if (div_done) begin
                  n_ff <= (div_quot > k0es_pkg::NUM_W'(k0es_pkg::NU_MAX))
                          ? k0es_pkg::NU_MAX : div_quot[k0es_pkg::NU_W-1:0];
               end
            end
            k0es_pkg::ST_BAND: begin
               if (n_ff > k0es_pkg::NU_LOW && n_ff < k0es_pkg::NU_HIGH) begin
                  n_ff <= k0es_pkg::NU_LOW;
               end
            end
            k0es_pkg::ST_MUL: begin
               em2_ff     <= young_ff * one_m_mag;
               em3_ff     <= young_ff * 25'(n_ff);
               den_mag_ff <= den_full[51] ? k0es_pkg::DEN_W'(-den_full)
                                          : k0es_pkg::DEN_W'(den_full);
               sign2_ff   <= one_m[24] ^ den_full[51];
               sign3_ff   <= den_full[51];
            end
            k0es_pkg::ST_C2_WAIT: begin
               if (div_done) c2_ff <= sign2_ff ? -$signed(coef_mag) : $signed(coef_mag);
            end
            k0es_pkg::ST_C3_WAIT: begin
               if (div_done) c3_ff <= sign3_ff ? -$signed(coef_mag) : $signed(coef_mag);
            end
            k0es_pkg::ST_C4_WAIT: begin
               if (div_done) c4_ff <= $signed(div_quot[k0es_pkg::COEF_W-1:0]);
            end
            default: ;
         endcase
      end
   end

   k0es_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign coef.c2   = c2_ff;
   assign coef.c3   = c3_ff;
   assign coef.c4   = c4_ff;
   assign coef.ka   = ka;
   assign coef.kb   = kb;
   assign coef.axis = axis_ff;
   assign busy      = state_ff != k0es_pkg::ST_IDLE;

endmodule
`default_nettype wire

@@ hdl/k0es_pipe.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// k0es_pipe: stress datapath
// Seven register stages from strain vector to saturated stress vector.
// ---------------------------------------------------------------------------
module k0es_pipe (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   input  wire logic signed [k0es_pkg::STRAIN_W-1:0] in_strain [6],
   input  wire k0es_pkg::coef_type                   coef,
   output logic                                      out_valid,
   output logic signed [k0es_pkg::STRESS_W-1:0]      out_stress [6],
   output logic                                      out_bad
);

   logic [6:0] v_ff;

   logic signed [k0es_pkg::STRAIN_W-1:0] e1_ff [6];
   logic signed [64:0] a_lo_ff [3], b_lo_ff [3], c_lo_ff [3];
   logic signed [63:0] a_hi_ff [3], b_hi_ff [3], c_hi_ff [3];
   logic signed [k0es_pkg::PROD_W-1:0]   pa_ff [3], pb_ff [3], pc_ff [3];
   logic signed [k0es_pkg::ACC_W-1:0]    acc_ff [6];
   logic signed [k0es_pkg::STRESS_W-1:0] s5_ff [6], s6_ff [6], s7_ff [6];
   logic signed [k0es_pkg::STRESS_W-1:0] s7_in [6];
   logic signed [k0es_pkg::LAT_W-1:0]    lat_a_ff, lat_b_ff;
   logic                                 bad_ff;

   logic signed [k0es_pkg::STRESS_W-1:0] main_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_comb begin
      case (coef.axis)
         k0es_pkg::AXIS_Y: main_s = s5_ff[1];
         k0es_pkg::AXIS_Z: main_s = s5_ff[2];
         default:          main_s = s5_ff[0];
      endcase
   end

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         s7_in[i] = s6_ff[i];
      end
      case (coef.axis)
         k0es_pkg::AXIS_X: begin
            s7_in[1] = k0es_pkg::sat_lat(lat_a_ff);
            s7_in[2] = k0es_pkg::sat_lat(lat_b_ff);
         end
         k0es_pkg::AXIS_Y: begin
            s7_in[2] = k0es_pkg::sat_lat(lat_a_ff);
            s7_in[0] = k0es_pkg::sat_lat(lat_b_ff);
         end
         k0es_pkg::AXIS_Z: begin
            s7_in[0] = k0es_pkg::sat_lat(lat_a_ff);
            s7_in[1] = k0es_pkg::sat_lat(lat_b_ff);
         end
         default: begin
            for (int i = 0; i < 6; i++) begin
               s7_in[i] = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) begin
         e1_ff[i] <= in_strain[i];
      end
      // Each wide coefficient is split in two halves so that no multiplier
      // exceeds a 33 by 32 bit product.
      for (int j = 0; j < 3; j++) begin
         a_lo_ff[j] <= $signed({1'b0, coef.c2[31:0]}) * e1_ff[j];
         a_hi_ff[j] <= $signed(coef.c2[63:32]) * e1_ff[j];
         b_lo_ff[j] <= $signed({1'b0, coef.c3[31:0]}) * e1_ff[j];
         b_hi_ff[j] <= $signed(coef.c3[63:32]) * e1_ff[j];
         c_lo_ff[j] <= $signed({1'b0, coef.c4[31:0]}) * e1_ff[j+3];
         c_hi_ff[j] <= $signed(coef.c4[63:32]) * e1_ff[j+3];
      end
      for (int j = 0; j < 3; j++) begin
         pa_ff[j] <= $signed({a_hi_ff[j], 32'b0}) + $signed({{31{a_lo_ff[j][64]}}, a_lo_ff[j]});
         pb_ff[j] <= $signed({b_hi_ff[j], 32'b0}) + $signed({{31{b_lo_ff[j][64]}}, b_lo_ff[j]});
         pc_ff[j] <= $signed({c_hi_ff[j], 32'b0}) + $signed({{31{c_lo_ff[j][64]}}, c_lo_ff[j]});
      end
      acc_ff[0] <= k0es_pkg::ACC_W'(pa_ff[0]) + k0es_pkg::ACC_W'(pb_ff[1])
                   + k0es_pkg::ACC_W'(pb_ff[2]);
      acc_ff[1] <= k0es_pkg::ACC_W'(pa_ff[1]) + k0es_pkg::ACC_W'(pb_ff[2])
                   + k0es_pkg::ACC_W'(pb_ff[0]);
      acc_ff[2] <= k0es_pkg::ACC_W'(pa_ff[2]) + k0es_pkg::ACC_W'(pb_ff[0])
                   + k0es_pkg::ACC_W'(pb_ff[1]);
      for (int j = 0; j < 3; j++) begin
         acc_ff[j+3] <= k0es_pkg::ACC_W'(pc_ff[j]);
      end
      for (int i = 0; i < 6; i++) begin
         s5_ff[i] <= k0es_pkg::sat_acc(acc_ff[i]);
         s6_ff[i] <= s5_ff[i];
      end
      lat_a_ff <= coef.ka * main_s;
      lat_b_ff <= coef.kb * main_s;
      for (int i = 0; i < 6; i++) begin
         s7_ff[i] <= s7_in[i];
      end
      bad_ff <= coef.axis == k0es_pkg::AXIS_BAD;
   end

   assign out_valid = v_ff[6];
   assign out_bad   = bad_ff;
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         out_stress[i] = s7_ff[i];
      end
   end

endmodule
`default_nettype wire

@@ hdl/k0_elastic_stress_update.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// k0_elastic_stress_update: K0-procedure linear elastic stress update
// Six-component strain in, six-component saturated stress out, per request.
// ---------------------------------------------------------------------------
// A request is taken on every clock edge where start is high and busy is low,
// one per cycle, and its stress comes out of the pipeline for a single cycle
// with rsp_valid high; the receiver cannot stall, so results must be taken as
// they come. Each result passes through the seven-stage multiply and accumulate
// pipeline. Out of reset the block is ready at once, since the reset modulus of
// zero makes every coefficient zero. From the cycle after every configuration
// write, busy stays high while the coefficient sequencer derives the Poisson
// ratio and the three matrix coefficients on its shared one-bit-per-cycle
// divider: four divisions of 88 steps when the ratio needs a division, and
// three when the ratio is zero without one.
module k0_elastic_stress_update (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [k0es_pkg::STRAIN_W-1:0] req_strain_xx,
   input  wire logic signed [k0es_pkg::STRAIN_W-1:0] req_strain_yy,
   input  wire logic signed [k0es_pkg::STRAIN_W-1:0] req_strain_zz,
   input  wire logic signed [k0es_pkg::STRAIN_W-1:0] req_shear_xy,
   input  wire logic signed [k0es_pkg::STRAIN_W-1:0] req_shear_yz,
   input  wire logic signed [k0es_pkg::STRAIN_W-1:0] req_shear_xz,
   output logic                                      rsp_valid,
   output logic signed [k0es_pkg::STRESS_W-1:0]      rsp_stress_xx,
   output logic signed [k0es_pkg::STRESS_W-1:0]      rsp_stress_yy,
   output logic signed [k0es_pkg::STRESS_W-1:0]      rsp_stress_zz,
   output logic signed [k0es_pkg::STRESS_W-1:0]      rsp_stress_xy,
   output logic signed [k0es_pkg::STRESS_W-1:0]      rsp_stress_yz,
   output logic signed [k0es_pkg::STRESS_W-1:0]      rsp_stress_xz,
   output logic                                      rsp_bad_axis,
   input  wire logic                                 csr_wr_en,
   input  wire logic [k0es_pkg::IDX_W-1:0]           csr_index,
   input  wire logic [k0es_pkg::E_W-1:0]             csr_wr_data
);

   k0es_pkg::coef_type coef;
   logic signed [k0es_pkg::STRAIN_W-1:0] strain [6];
   logic signed [k0es_pkg::STRESS_W-1:0] stress [6];
   logic accept;

   assign accept    = start && !busy;
   assign strain[0] = req_strain_xx;
   assign strain[1] = req_strain_yy;
   assign strain[2] = req_strain_zz;
   assign strain[3] = req_shear_xy;
   assign strain[4] = req_shear_yz;
   assign strain[5] = req_shear_xz;

   k0es_coef u_coef (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .coef        (coef),
      .busy        (busy)
   );

   k0es_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_strain  (strain),
      .coef       (coef),
      .out_valid  (rsp_valid),
      .out_stress (stress),
      .out_bad    (rsp_bad_axis)
   );

   assign rsp_stress_xx = stress[0];
   assign rsp_stress_yy = stress[1];
   assign rsp_stress_zz = stress[2];
   assign rsp_stress_xy = stress[3];
   assign rsp_stress_yz = stress[4];
   assign rsp_stress_xz = stress[5];

endmodule
`default_nettype wire

@@ bench/k0_elastic_stress_update_test.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// k0_elastic_stress_update_test: self-checking bench for the K0 stress update
// Directed and random strain requests under several register settings; every
// stress result is checked against a bit-exact fixed-point prediction.
// ---------------------------------------------------------------------------
module k0_elastic_stress_update_test;

   typedef struct {
      bit                                   is_write;
      logic [k0es_pkg::IDX_W-1:0]           idx;
      logic [k0es_pkg::E_W-1:0]             data;
      logic signed [k0es_pkg::STRAIN_W-1:0] strain [6];
      int                                   gap;
   } pending_type;

   typedef struct {
      logic signed [k0es_pkg::STRESS_W-1:0] stress [6];
      logic                                 bad;
   } stress_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   logic signed [k0es_pkg::STRAIN_W-1:0] req_strain [6] = '{6{32'sd0}};
   logic                                 rsp_valid;
   logic signed [k0es_pkg::STRESS_W-1:0] rsp_stress [6];
   logic                                 rsp_bad_axis;
   logic                                 csr_wr_en = 1'b0;
   logic [k0es_pkg::IDX_W-1:0]           csr_index = '0;
   logic [k0es_pkg::E_W-1:0]             csr_wr_data = '0;

   pending_type pending [$];
   stress_type  stress_due [$];
   int          failures = 0;
   int          gap_left = 0;
   int          issued = 0;
   int          accepted = 0;
   bit          gaps_on = 1'b1;
   string       field_name [6] = '{"stress_xx", "stress_yy", "stress_zz",
                                   "stress_xy", "stress_yz", "stress_xz"};

   // Shadow copy of the configuration registers.
   logic [k0es_pkg::E_W-1:0]        sh_young = '0;
   logic signed [k0es_pkg::K_W-1:0] sh_k0 [3] = '{k0es_pkg::K0_RESET, k0es_pkg::K0_RESET,
                                                  k0es_pkg::K0_RESET};
   logic [k0es_pkg::AXIS_W-1:0]     sh_axis = k0es_pkg::AXIS_Z;

   k0_elastic_stress_update i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_strain_xx (req_strain[0]),
      .req_strain_yy (req_strain[1]),
      .req_strain_zz (req_strain[2]),
      .req_shear_xy  (req_strain[3]),
      .req_shear_yz  (req_strain[4]),
      .req_shear_xz  (req_strain[5]),
      .rsp_valid     (rsp_valid),
      .rsp_stress_xx (rsp_stress[0]),
      .rsp_stress_yy (rsp_stress[1]),
      .rsp_stress_zz (rsp_stress[2]),
      .rsp_stress_xy (rsp_stress[3]),
      .rsp_stress_yz (rsp_stress[4]),
      .rsp_stress_xz (rsp_stress[5]),
      .rsp_bad_axis  (rsp_bad_axis),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Rounded (half up) arithmetic shift, then clamp to the stress width.
   function automatic logic signed [k0es_pkg::STRESS_W-1:0] round_clamp(
         logic signed [127:0] x, int sh);
      logic signed [127:0] one, t, top, bottom;
      one = 1;
      top = (one <<< (k0es_pkg::STRESS_W - 1)) - 1;
      bottom = -top - 1;
      t = (x + (one <<< (sh - 1))) >>> sh;
      if (t > top) return top[k0es_pkg::STRESS_W-1:0];
      if (t < bottom) return bottom[k0es_pkg::STRESS_W-1:0];
      return t[k0es_pkg::STRESS_W-1:0];
   endfunction

   // E * m / den in kPa with 16 fraction bits, rounded half away from zero.
   function automatic logic signed [127:0] matrix_coef(logic [k0es_pkg::E_W-1:0] young,
                                                       logic signed [63:0] m,
                                                       logic signed [63:0] den);
      logic [127:0] num, d, q, cap;
      logic [63:0]  mm;
      mm = m < 0 ? -m : m;
      d = den < 0 ? -den : den;
      num = (128'(young) * 128'(mm)) << 32;
      q = (2 * num + d) / (2 * d);
      cap = 128'd1 << 62;
      if (q > cap) q = cap;
      return ((m < 0) != (den < 0)) ? -$signed(q) : $signed(q);
   endfunction

   function automatic stress_type stress_of(logic signed [k0es_pkg::STRAIN_W-1:0] strain [6]);
      stress_type          r;
      logic signed [127:0] ev [6];
      logic signed [127:0] kv [3];
      logic signed [127:0] c2, c3, c4, acc;
      logic signed [63:0]  kq, dk, nu, den;
      logic [63:0]         q, dd;
      int                  m, a, b;
      for (int i = 0; i < 6; i++) begin
         r.stress[i] = '0;
         ev[i] = strain[i];
      end
      r.bad = (sh_axis == k0es_pkg::AXIS_BAD);
      if (r.bad) return r;
      for (int i = 0; i < 3; i++) kv[i] = sh_k0[i];
      m = sh_axis;
      a = (m + 1) % 3;
      b = (m + 2) % 3;
      kq = 64'(sh_k0[a]) + 64'(sh_k0[b]);
      dk = kq + 32768;
      nu = 0;
      if ((kq > 0 && dk > 0) || (kq < 0 && dk < 0)) begin
         q = (2 * ((kq < 0 ? -kq : kq) << 16) + (dk < 0 ? -dk : dk)) /
             (2 * (dk < 0 ? -dk : dk));
         nu = q > k0es_pkg::NU_MAX ? 64'(k0es_pkg::NU_MAX) : q;
      end
      // Ratios close to one half would make the matrix singular.
      if (nu > k0es_pkg::NU_LOW && nu < k0es_pkg::NU_HIGH) nu = k0es_pkg::NU_LOW;
      den = (65536 + nu) * (65536 - 2 * nu);
      c2 = matrix_coef(sh_young, 65536 - nu, den);
      c3 = matrix_coef(sh_young, nu, den);
      dd = 65536 + nu;
      c4 = $signed(((128'(sh_young) << 31) + dd / 2) / dd);
      for (int i = 0; i < 3; i++) begin
         acc = c2 * ev[i] + c3 * ev[(i + 1) % 3] + c3 * ev[(i + 2) % 3];
         r.stress[i] = round_clamp(acc, 29);
         r.stress[i + 3] = round_clamp(c4 * ev[i + 3], 29);
      end
      acc = r.stress[m];
      r.stress[a] = round_clamp(kv[a] * acc, 14);
      r.stress[b] = round_clamp(kv[b] * acc, 14);
      return r;
   endfunction

   // Driver: one request or register write per free slot, after its idle gap.
   always @(negedge clock) begin
      bit next_start, next_wr;
      pending_type p;
      next_start = start && (accepted != issued);
      next_wr = 1'b0;
      if (!reset && !next_start) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending.size() > 0) begin
            p = pending[0];
            if (!p.is_write) begin
               req_strain <= p.strain;
               next_start = 1'b1;
               issued++;
               gap_left = p.gap;
               void'(pending.pop_front());
            end else if (stress_due.size() == 0) begin
               csr_index <= p.idx;
               csr_wr_data <= p.data;
               next_wr = 1'b1;
               case (p.idx)
                  k0es_pkg::REG_YOUNG: sh_young = p.data;
                  k0es_pkg::REG_K0_X:  sh_k0[0] = p.data[k0es_pkg::K_W-1:0];
                  k0es_pkg::REG_K0_Y:  sh_k0[1] = p.data[k0es_pkg::K_W-1:0];
                  k0es_pkg::REG_K0_Z:  sh_k0[2] = p.data[k0es_pkg::K_W-1:0];
                  k0es_pkg::REG_AXIS:  sh_axis = p.data[k0es_pkg::AXIS_W-1:0];
                  default: ;
               endcase
               gap_left = p.gap;
               void'(pending.pop_front());
            end
         end
      end
      start <= next_start;
      csr_wr_en <= next_wr;
   end

   // Monitor: predict on acceptance, check each strobed result.
   always @(posedge clock) begin
      stress_type want;
      if (!reset) begin
         if (start && !busy && accepted != issued) begin
            stress_due.insert(stress_due.size(), stress_of(req_strain));
            accepted++;
         end
         if (rsp_valid) begin
            if (stress_due.size() == 0) begin
               $error("stress result with no request outstanding");
               failures++;
            end else begin
               want = stress_due.pop_front();
               for (int i = 0; i < 6; i++) begin
                  if (rsp_stress[i] !== want.stress[i]) begin
                     $error("%s: expected %0d, got %0d", field_name[i], want.stress[i],
                            rsp_stress[i]);
                     failures++;
                  end
               end
               if (rsp_bad_axis !== want.bad) begin
                  $error("bad_axis: expected %0d, got %0d", want.bad, rsp_bad_axis);
                  failures++;
               end
            end
         end
      end
   end

   function automatic int draw_gap();
      return gaps_on ? $urandom_range(0, 12) : 0;
   endfunction

   task automatic queue_write(logic [k0es_pkg::IDX_W-1:0] idx, logic [k0es_pkg::E_W-1:0] data);
      pending_type p;
      p.is_write = 1'b1;
      p.idx = idx;
      p.data = data;
      p.gap = draw_gap();
      pending.insert(pending.size(), p);
   endtask

   task automatic queue_config(logic [k0es_pkg::E_W-1:0] young,
                               logic signed [k0es_pkg::K_W-1:0] kx,
                               logic signed [k0es_pkg::K_W-1:0] ky,
                               logic signed [k0es_pkg::K_W-1:0] kz,
                               logic [k0es_pkg::AXIS_W-1:0] axis);
      queue_write(k0es_pkg::REG_YOUNG, young);
      queue_write(k0es_pkg::REG_K0_X, k0es_pkg::E_W'(kx));
      queue_write(k0es_pkg::REG_K0_Y, k0es_pkg::E_W'(ky));
      queue_write(k0es_pkg::REG_K0_Z, k0es_pkg::E_W'(kz));
      queue_write(k0es_pkg::REG_AXIS, k0es_pkg::E_W'(axis));
   endtask

   task automatic queue_request(logic signed [k0es_pkg::STRAIN_W-1:0] v0,
                                logic signed [k0es_pkg::STRAIN_W-1:0] v1,
                                logic signed [k0es_pkg::STRAIN_W-1:0] v2,
                                logic signed [k0es_pkg::STRAIN_W-1:0] v3,
                                logic signed [k0es_pkg::STRAIN_W-1:0] v4,
                                logic signed [k0es_pkg::STRAIN_W-1:0] v5);
      pending_type p;
      p.is_write = 1'b0;
      p.strain = '{v0, v1, v2, v3, v4, v5};
      p.gap = draw_gap();
      pending.insert(pending.size(), p);
   endtask

   function automatic logic signed [k0es_pkg::STRAIN_W-1:0] rand_strain();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sd0;
         3, 4: return {{12{r[19]}}, r[19:0]};
         default: return r;
      endcase
   endfunction

   function automatic logic signed [k0es_pkg::K_W-1:0] rand_k0();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 6))
         0: return 19'sh40000;
         1: return 19'sh3FFFF;
         2: return 19'sd16384;
         3, 4: return k0es_pkg::K_W'($urandom_range(0, 32768));
         default: return r[k0es_pkg::K_W-1:0];
      endcase
   endfunction

   function automatic logic [k0es_pkg::E_W-1:0] rand_young();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return k0es_pkg::E_W'($urandom_range(1000, 500000));
         default: return k0es_pkg::E_W'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [k0es_pkg::STRAIN_W-1:0] lo, hi;
      lo = 32'sh8000_0000;
      hi = 32'sh7FFF_FFFF;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Reset settings: zero modulus gives zero stress everywhere.
      queue_request(hi, lo, 1, -1, hi, lo);
      queue_config('1, 19'sd8192, 19'sd8192, 19'sd8192, k0es_pkg::AXIS_X);
      queue_request(hi, hi, hi, hi, hi, hi);
      queue_request(lo, lo, lo, lo, lo, lo);
      queue_request(32'sd536870912, -32'sd536870912, 0, 32'sd1, -32'sd1, 32'sd12345);
      queue_write(k0es_pkg::REG_AXIS, k0es_pkg::E_W'(k0es_pkg::AXIS_Y));
      queue_request(32'sd1000000, -32'sd200000, 32'sd3, hi, lo, 0);
      queue_write(k0es_pkg::REG_AXIS, k0es_pkg::E_W'(k0es_pkg::AXIS_Z));
      queue_request(-32'sd1000000, 32'sd200000, 32'sd7, lo, hi, 1);
      // Invalid main axis: error flag and zero stress.
      queue_write(k0es_pkg::REG_AXIS, k0es_pkg::E_W'(k0es_pkg::AXIS_BAD));
      queue_request(hi, lo, hi, lo, hi, lo);
      // Mean K0 of exactly -1: zero divisor.
      queue_config(30'd200000, -19'sd16384, -19'sd16384, 19'sd8192, k0es_pkg::AXIS_Z);
      queue_request(32'sd5368709, -32'sd5368709, 32'sd536870, 32'sd1000, 0, -32'sd1000);
      // Mean K0 just below -1: ratio saturates.
      queue_config(30'd200000, -19'sd16384, -19'sd16385, 19'sd4000, k0es_pkg::AXIS_Z);
      queue_request(32'sd5368709, -32'sd5368709, 32'sd536870, 32'sd1000, 0, -32'sd1000);
      // Mean K0 near one: ratio inside the band around one half.
      queue_config(30'd200000, 19'sd16384, 19'sd16384, 19'sd16384, k0es_pkg::AXIS_Z);
      queue_request(32'sd5368709, -32'sd5368709, 32'sd536870, 32'sd1000, 0, -32'sd1000);
      queue_config('1, 19'sh3FFFF, 19'sh40000, 19'sh3FFFF, k0es_pkg::AXIS_X);
      queue_request(hi, lo, hi, 1, -1, 0);
      queue_request(32'sd1, 32'sd1, -32'sd1, 0, 0, 0);
      // Out-of-range index must be ignored.
      queue_write(3'd7, '1);
      queue_request(32'sd99999, -32'sd5, 32'sd12, 32'sd77, -32'sd77, 32'sd3);

      for (int ph = 0; ph < 16; ph++) begin
         gaps_on = (ph % 4) != 3;
         queue_config(rand_young(), rand_k0(), rand_k0(), rand_k0(),
                      $urandom_range(0, 9) == 0 ? k0es_pkg::AXIS_BAD
                                                : k0es_pkg::AXIS_W'($urandom_range(0, 2)));
         if ($urandom_range(0, 3) == 0) begin
            queue_write(k0es_pkg::IDX_W'($urandom_range(5, 7)), k0es_pkg::E_W'($urandom));
         end
         repeat (75) queue_request(rand_strain(), rand_strain(), rand_strain(),
                                   rand_strain(), rand_strain(), rand_strain());
      end

      while (pending.size() > 0 || start || stress_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire
